/* sv/distance_lod_level_select_macros.svh */
// Assertion macros for the distance LOD level select checker.
// Used by the bound checker only; no dependencies.
`ifndef DISTANCE_LOD_LEVEL_SELECT_MACROS_SVH
`define DISTANCE_LOD_LEVEL_SELECT_MACROS_SVH

// clocked assertion, switched off while reset is held
`define DLS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also covers the reset cycles
`define DLS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/dls_pkg.sv */
// Shared types and constants for the distance LOD level select block.
// No dependencies.
package dls_pkg;

  localparam int CAM_W        = 24;
  localparam int FAR_W        = 24;
  localparam int LVL_W        = 6;
  localparam int SQ_RAD_W     = 2 * FAR_W + 2;   // sum of three 24-bit squares
  localparam int SQ_ROOT_W    = SQ_RAD_W / 2;
  localparam int SQ_REM_W     = SQ_ROOT_W + 2;
  localparam int DIV_REM_W    = FAR_W + 1;
  localparam int CFG_IDX_W    = 3;
  localparam int DEF_COORD_BITS      = 24;
  localparam int DEF_RATIO_FRAC_BITS = 16;

  localparam logic [LVL_W-1:0] INVALID_LEVEL = 6'd63;
  localparam logic [FAR_W-1:0] FAR_RESET     = 24'd256000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAMERA_X   = 3'd0,
    CFG_CAMERA_Y   = 3'd1,
    CFG_CAMERA_Z   = 3'd2,
    CFG_FAR        = 3'd3,
    CFG_LEVEL_CNT  = 3'd4,
    CFG_HYST_EN    = 3'd5
  } cfg_idx_t;

  // data riding alongside the arithmetic through the cell chains
  typedef struct packed {
    logic             sat;
    logic [LVL_W-1:0] prior;
  } side_t;

endpackage

/* sv/dls_sqrt_cell.sv */
// One digit cell of the square root chain: two radicand bits per cell.
// Depends on dls_pkg.
module dls_sqrt_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_v,
  input  logic [dls_pkg::SQ_RAD_W-1:0]  in_rad,
  input  logic [dls_pkg::SQ_REM_W-1:0]  in_rem,
  input  logic [dls_pkg::SQ_ROOT_W-1:0] in_root,
  input  dls_pkg::side_t                in_side,
  output logic                          out_v,
  output logic [dls_pkg::SQ_RAD_W-1:0]  out_rad,
  output logic [dls_pkg::SQ_REM_W-1:0]  out_rem,
  output logic [dls_pkg::SQ_ROOT_W-1:0] out_root,
  output dls_pkg::side_t                out_side
);
  import dls_pkg::*;

  logic [SQ_REM_W-1:0] rem2, trial;
  logic                ge;
  logic                v_r;
  logic [SQ_RAD_W-1:0] rad_r;
  logic [SQ_REM_W-1:0] rem_r;
  logic [SQ_ROOT_W-1:0] root_r;
  side_t               side_r;

  always_comb begin
    rem2  = {in_rem[SQ_REM_W-3:0], in_rad[SQ_RAD_W-1 -: 2]};
    trial = {in_root, 2'b01};
    ge    = (rem2 >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rad_r  <= {in_rad[SQ_RAD_W-3:0], 2'b00};
      rem_r  <= ge ? (rem2 - trial) : rem2;
      root_r <= {in_root[SQ_ROOT_W-2:0], ge};
      side_r <= in_side;
    end
  end

  assign out_v    = v_r;
  assign out_rad  = rad_r;
  assign out_rem  = rem_r;
  assign out_root = root_r;
  assign out_side = side_r;

endmodule

/* sv/dls_div_cell.sv */
// One quotient bit cell of the restoring divider chain.
// Depends on dls_pkg.
module dls_div_cell #(
  parameter int Q_W = dls_pkg::DEF_RATIO_FRAC_BITS + 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic [dls_pkg::FAR_W-1:0]     far,
  input  logic                          in_v,
  input  logic [dls_pkg::DIV_REM_W-1:0] in_rem,
  input  logic [Q_W-1:0]                in_bits,
  input  logic [Q_W-1:0]                in_q,
  input  dls_pkg::side_t                in_side,
  output logic                          out_v,
  output logic [dls_pkg::DIV_REM_W-1:0] out_rem,
  output logic [Q_W-1:0]                out_bits,
  output logic [Q_W-1:0]                out_q,
  output dls_pkg::side_t                out_side
);
  import dls_pkg::*;

  logic [DIV_REM_W-1:0] rem2;
  logic                 ge;
  logic                 v_r;
  logic [DIV_REM_W-1:0] rem_r;
  logic [Q_W-1:0]       bits_r, q_r;
  side_t                side_r;

  always_comb begin
    rem2 = {in_rem[DIV_REM_W-2:0], in_bits[Q_W-1]};
    ge   = (rem2 >= {1'b0, far});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r  <= ge ? (rem2 - {1'b0, far}) : rem2;
      bits_r <= {in_bits[Q_W-2:0], 1'b0};
      q_r    <= {in_q[Q_W-2:0], ge};
      side_r <= in_side;
    end
  end

  assign out_v    = v_r;
  assign out_rem  = rem_r;
  assign out_bits = bits_r;
  assign out_q    = q_r;
  assign out_side = side_r;

endmodule

/* sv/distance_lod_level_select.sv */
// Distance based LOD level select: top level, front stages, cell chains, level pick.
// Depends on dls_pkg, dls_sqrt_cell and dls_div_cell.
//
// Usage:
//   in_*  : one transaction per terrain patch; in_tdata holds center_x, center_y,
//           center_z (COORD_BITS each, signed Q16.8) and prior_level (6 bits).
//   out_* : one transaction per patch, in order; out_tdata[5:0] is new_level,
//           out_tuser is level_invalid.
//   cfg_* : register writes (index, data), always ready; write only while idle.
// The pipe holds three front stages (differences, squares, sum and range
// check), 25 square root cells, one divider cell per ratio bit, and the output
// register. Throughput is one patch per cycle while the output is not stalled;
// the whole pipe moves together.
// Reset clears all valid bits and loads the register defaults (camera at the
// origin, far plane 256000, level count 0, hysteresis off).
// When the receiver stalls with a result pending, the pipe freezes and
// in_tready drops until the output register is taken.
module distance_lod_level_select #(
  parameter int COORD_BITS      = dls_pkg::DEF_COORD_BITS,
  parameter int RATIO_FRAC_BITS = dls_pkg::DEF_RATIO_FRAC_BITS,
  localparam int IN_W = ((3 * COORD_BITS + dls_pkg::LVL_W + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // center_x, center_y, center_z, prior_level, zero pad (lowest first)
  input  logic [IN_W-1:0]               in_tdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // new_level, zero pad
  output logic [7:0]                    out_tdata,
  // level_invalid
  output logic                          out_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import dls_pkg::*;

  localparam int DW  = ((COORD_BITS > CAM_W) ? COORD_BITS : CAM_W) + 1;
  localparam int Q_W = RATIO_FRAC_BITS + 1;
  localparam int XW  = Q_W + LVL_W;
  localparam int NSQ = SQ_ROOT_W;

  logic adv;

  // configuration registers
  logic [CAM_W-1:0] cam_x_r, cam_y_r, cam_z_r;
  logic [FAR_W-1:0] far_r;
  logic [LVL_W-1:0] lc_r;
  logic             hyst_r;
  logic [2*FAR_W-1:0] far_sq_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r <= '0;
      cam_y_r <= '0;
      cam_z_r <= '0;
      far_r   <= FAR_RESET;
      lc_r    <= '0;
      hyst_r  <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CAMERA_X:  cam_x_r <= cfg_data[CAM_W-1:0];
        CFG_CAMERA_Y:  cam_y_r <= cfg_data[CAM_W-1:0];
        CFG_CAMERA_Z:  cam_z_r <= cfg_data[CAM_W-1:0];
        CFG_FAR:       far_r   <= cfg_data[FAR_W-1:0];
        CFG_LEVEL_CNT: lc_r    <= cfg_data[LVL_W-1:0];
        CFG_HYST_EN:   hyst_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    far_sq_r <= far_r * far_r;
  end

  // stage 1: absolute differences and coarse range check
  logic signed [DW-1:0] dxs, dys, dzs;
  logic [DW-1:0]        adx, ady, adz;
  logic                 big;

  always_comb begin
    dxs = DW'($signed(cam_x_r)) - DW'($signed(in_tdata[0 +: COORD_BITS]));
    dys = DW'($signed(cam_y_r)) - DW'($signed(in_tdata[COORD_BITS +: COORD_BITS]));
    dzs = DW'($signed(cam_z_r)) - DW'($signed(in_tdata[2*COORD_BITS +: COORD_BITS]));
    adx = dxs[DW-1] ? DW'(-dxs) : DW'(dxs);
    ady = dys[DW-1] ? DW'(-dys) : DW'(dys);
    adz = dzs[DW-1] ? DW'(-dzs) : DW'(dzs);
    big = (far_r == '0) || (adx > DW'(far_r)) || (ady > DW'(far_r)) ||
          (adz > DW'(far_r));
  end

  logic             s1_v_r, s2_v_r, s3_v_r;
  logic [FAR_W-1:0] s1_dx_r, s1_dy_r, s1_dz_r;
  side_t            s1_side_r, s2_side_r, s3_side_r;
  logic [2*FAR_W-1:0] s2_x2_r, s2_y2_r, s2_z2_r;
  logic [SQ_RAD_W-1:0] d2, s3_d2_r;

  assign d2 = SQ_RAD_W'(s2_x2_r) + SQ_RAD_W'(s2_y2_r) + SQ_RAD_W'(s2_z2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_tvalid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dx_r         <= adx[FAR_W-1:0];
      s1_dy_r         <= ady[FAR_W-1:0];
      s1_dz_r         <= adz[FAR_W-1:0];
      s1_side_r.sat   <= big;
      s1_side_r.prior <= in_tdata[3*COORD_BITS +: LVL_W];
      s2_x2_r         <= s1_dx_r * s1_dx_r;
      s2_y2_r         <= s1_dy_r * s1_dy_r;
      s2_z2_r         <= s1_dz_r * s1_dz_r;
      s2_side_r       <= s1_side_r;
      s3_d2_r         <= d2;
      s3_side_r.sat   <= s2_side_r.sat || (d2 > SQ_RAD_W'(far_sq_r));
      s3_side_r.prior <= s2_side_r.prior;
    end
  end

  // square root chain
  logic                 sq_v    [0:NSQ];
  logic [SQ_RAD_W-1:0]  sq_rad  [0:NSQ];
  logic [SQ_REM_W-1:0]  sq_rem  [0:NSQ];
  logic [SQ_ROOT_W-1:0] sq_root [0:NSQ];
  side_t                sq_side [0:NSQ];

  assign sq_v[0]    = s3_v_r;
  assign sq_rad[0]  = s3_d2_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = s3_side_r;

  for (genvar i = 0; i < NSQ; i++) begin : g_sqrt
    dls_sqrt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .in_v     (sq_v[i]),
      .in_rad   (sq_rad[i]),
      .in_rem   (sq_rem[i]),
      .in_root  (sq_root[i]),
      .in_side  (sq_side[i]),
      .out_v    (sq_v[i+1]),
      .out_rad  (sq_rad[i+1]),
      .out_rem  (sq_rem[i+1]),
      .out_root (sq_root[i+1]),
      .out_side (sq_side[i+1])
    );
  end

  // divider chain: the quotient stays below 2^(RATIO_FRAC_BITS+1) since dist <= far
  logic                 dv_v    [0:Q_W];
  logic [DIV_REM_W-1:0] dv_rem  [0:Q_W];
  logic [Q_W-1:0]       dv_bits [0:Q_W];
  logic [Q_W-1:0]       dv_q    [0:Q_W];
  side_t                dv_side [0:Q_W];

  assign dv_v[0]    = sq_v[NSQ];
  assign dv_rem[0]  = DIV_REM_W'(sq_root[NSQ][SQ_ROOT_W-1:1]);
  assign dv_bits[0] = {sq_root[NSQ][0], {RATIO_FRAC_BITS{1'b0}}};
  assign dv_q[0]    = '0;
  assign dv_side[0] = sq_side[NSQ];

  for (genvar j = 0; j < Q_W; j++) begin : g_div
    dls_div_cell #(.Q_W(Q_W)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .far      (far_r),
      .in_v     (dv_v[j]),
      .in_rem   (dv_rem[j]),
      .in_bits  (dv_bits[j]),
      .in_q     (dv_q[j]),
      .in_side  (dv_side[j]),
      .out_v    (dv_v[j+1]),
      .out_rem  (dv_rem[j+1]),
      .out_bits (dv_bits[j+1]),
      .out_q    (dv_q[j+1]),
      .out_side (dv_side[j+1])
    );
  end

  // level pick
  localparam logic [XW-1:0] HALF = XW'(1) << (RATIO_FRAC_BITS - 1);

  logic [Q_W-1:0]   ratio;
  logic [XW-1:0]    x, xh, xl;
  logic [LVL_W:0]   cur, hi, lo, prior7, lvl;
  logic [LVL_W-1:0] new_level;
  logic             invalid;

  always_comb begin
    ratio  = dv_side[Q_W].sat ? (Q_W'(1) << RATIO_FRAC_BITS) : dv_q[Q_W];
    x      = XW'(ratio) * XW'(lc_r);
    xh     = x + HALF;
    xl     = x - HALF;
    cur    = x[RATIO_FRAC_BITS +: LVL_W+1];
    hi     = xh[RATIO_FRAC_BITS +: LVL_W+1];
    lo     = (x >= HALF) ? xl[RATIO_FRAC_BITS +: LVL_W+1] : '0;
    // an invalid prior ranks above every level
    prior7 = (dv_side[Q_W].prior == INVALID_LEVEL) ? (LVL_W+1)'(64)
                                                   : {1'b0, dv_side[Q_W].prior};
    lvl    = cur;
    if (hyst_r) begin
      lvl = prior7;
      if ((prior7 < cur) && (prior7 < lo)) begin
        lvl = cur;
      end else if ((prior7 > cur) && (prior7 > hi)) begin
        lvl = cur;
      end
    end
    invalid   = (lvl > {1'b0, lc_r});
    new_level = invalid ? INVALID_LEVEL : lvl[LVL_W-1:0];
  end

  logic             out_v_r;
  logic [LVL_W-1:0] out_lvl_r;
  logic             out_inv_r;

  assign adv       = !out_v_r || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= dv_v[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_lvl_r <= new_level;
      out_inv_r <= invalid;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, out_lvl_r};
  assign out_tuser  = out_inv_r;

endmodule

/* sv/dls_checker.sv */
// Port-level checker for distance_lod_level_select, bound to the top level.
// Depends on dls_pkg and distance_lod_level_select_macros.svh.
`include "distance_lod_level_select_macros.svh"

module dls_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tuser
);
  import dls_pkg::*;

  `DLS_ASSERT_RST(a_no_out_after_reset, !rst_n |=> !out_tvalid, "result valid after reset")
  `DLS_ASSERT(a_stall_blocks_input, (out_tvalid && !out_tready) |-> !in_tready, "input taken during stall")
  `DLS_ASSERT(a_invalid_code, (out_tvalid && out_tuser) |-> (out_tdata[5:0] == INVALID_LEVEL), "invalid flag without invalid code")
  `DLS_ASSERT(a_out_held, (out_tvalid && !out_tready) |=> out_tvalid, "result dropped while stalled")

endmodule

bind distance_lod_level_select dls_checker u_dls_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
